// ----- hw/rtl/cwsm_pkg.sv -----
// Package for the chassis wheel speed mixer.
// Holds the sequencer state type, the fixed-point constants and the arctangent table.
// Depends on nothing.
package cwsm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_ROUND,
    ST_ROTATE,
    ST_MIX,
    ST_MAX,
    ST_SCALE_MUL,
    ST_SCALE_DIV
  } cwsm_state_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2,
    DIR_ODD  = 2'd3
  } cwsm_dir_e;

  typedef enum logic [1:0] {
    REG_MAX_LIMIT = 2'd0,
    REG_DEADBAND  = 2'd1,
    REG_SPIN_THR  = 2'd2,
    REG_UNUSED    = 2'd3
  } cwsm_reg_e;

  localparam logic signed [31:0] Q28_HALF_PI = 32'sd421657428;
  localparam logic signed [31:0] Q28_PI      = 32'sd843314857;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008217;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned DivSteps    = 18;

  function automatic logic signed [31:0] atan_q28(input logic [3:0] idx);
    logic signed [31:0] v;
    unique case (idx)
      4'd0:  v = 32'sd210828714;
      4'd1:  v = 32'sd124459457;
      4'd2:  v = 32'sd65760959;
      4'd3:  v = 32'sd33381290;
      4'd4:  v = 32'sd16755422;
      4'd5:  v = 32'sd8385879;
      4'd6:  v = 32'sd4193963;
      4'd7:  v = 32'sd2097109;
      4'd8:  v = 32'sd1048571;
      4'd9:  v = 32'sd524287;
      4'd10: v = 32'sd262144;
      4'd11: v = 32'sd131072;
      4'd12: v = 32'sd65536;
      4'd13: v = 32'sd32768;
      4'd14: v = 32'sd16384;
      default: v = 32'sd8192;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/chassis_wheel_speed_mixer.sv -----
// Chassis wheel speed mixer: mecanum inverse kinematics with speed limiting.
// Single module built on one CORDIC stage, one multiplier and one divider step.
// Depends on cwsm_pkg.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------------
//   in      | in        | in_valid_i / in_stall_o   | yaw, vx, vy, wz, correction, flag
//   out     | out       | out_valid_o / out_stall_i | four wheel speeds, spinning
//   cfg     | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// Each accepted transaction runs the 16 CORDIC iterations, the rotation and the mix; when
// the four wheels are scaled, the 18-step restoring division then runs once per wheel. A
// no-force transaction skips all of these and goes straight to the result register. The
// block accepts a new transaction only when its sequencer is idle and no finished result
// waits, and the output register lets a finished result wait while the next transaction
// is taken. Reset is asynchronous and clears the sequencer, the remembered spin direction
// and the configuration to their defaults.
module chassis_wheel_speed_mixer
  import cwsm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [16:0]        cfg_data_i,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [14:0] yaw_angle_i,
  input  logic signed [15:0] cmd_vx_i,
  input  logic signed [15:0] cmd_vy_i,
  input  logic signed [15:0] cmd_wz_i,
  input  logic signed [15:0] follow_correction_i,
  input  logic               no_force_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [17:0] speed_left_back_o,
  output logic signed [17:0] speed_right_back_o,
  output logic signed [17:0] speed_right_front_o,
  output logic signed [17:0] speed_left_front_o,
  output logic               spinning_o
);

  // Configuration registers.
  logic [16:0]        lim_q;
  logic [13:0]        deadband_q;
  logic signed [15:0] spin_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q      <= 17'd131071;
      deadband_q <= 14'd205;
      spin_thr_q <= 16'sd26;
    end else if (cfg_we_i) begin
      unique case (cwsm_reg_e'(cfg_idx_i))
        REG_MAX_LIMIT: lim_q      <= cfg_data_i;
        REG_DEADBAND:  deadband_q <= cfg_data_i[13:0];
        REG_SPIN_THR:  spin_thr_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  cwsm_state_e        state_q, state_d;
  cwsm_dir_e          dir_q, dir_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [1:0]         idx_q, idx_d;
  logic               done_q, done_d;

  logic signed [14:0] yaw_q, yaw_d;
  logic signed [15:0] vx_q, vx_d, vy_q, vy_d, wzc_q, wzc_d, corr_q, corr_d;
  logic               neg_q, neg_d;
  logic signed [31:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [17:0] c_q, c_d, s_q, s_d;
  logic signed [37:0] acc_q, acc_d;
  logic signed [17:0] rx_q, rx_d, ry_q, ry_d;
  logic signed [17:0] w_q [4];
  logic signed [17:0] w_d [4];
  logic               spin_q, spin_d;
  logic [17:0]        m_q, m_d;
  logic [18:0]        rem_q, rem_d;
  logic [17:0]        sh_q, sh_d;

  logic               out_valid_q, out_valid_d;
  logic signed [17:0] out_w_q [4];
  logic signed [17:0] out_w_d [4];
  logic               out_spin_q, out_spin_d;

  // Shared multiplier.
  logic signed [18:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [36:0] prod;

  // Combinational helpers.
  logic signed [31:0] z_init, dx, dy, xr, yr;
  logic signed [37:0] acc_sum;
  logic signed [17:0] wz_sel;
  logic signed [19:0] mix [4];
  logic [17:0]        aw [4];
  logic [17:0]        m01, m23;
  logic [14:0]        ayaw;
  logic [35:0]        num;
  logic [19:0]        trial, dvs;
  logic               qbit;
  logic [17:0]        cur_abs;
  logic               cur_neg;
  logic               accept;

  assign accept = in_valid_i && !in_stall_o;
  assign prod   = mul_a * mul_b;

  always_comb begin
    z_init = 32'(yaw_angle_i) <<< 16;
    dx     = y_q >>> cnt_q[3:0];
    dy     = x_q >>> cnt_q[3:0];
    xr     = (x_q + 32'sd8192) >>> 14;
    yr     = (y_q + 32'sd8192) >>> 14;
    ayaw   = yaw_q[14] ? 15'(-yaw_q) : 15'(yaw_q);
    for (int i = 0; i < 4; i++) begin
      aw[i] = w_q[i][17] ? 18'(-w_q[i]) : 18'(w_q[i]);
    end
    m01     = (aw[0] > aw[1]) ? aw[0] : aw[1];
    m23     = (aw[2] > aw[3]) ? aw[2] : aw[3];
    cur_abs = aw[idx_q];
    cur_neg = w_q[idx_q][17];
    num     = {prod[34:0], 1'b0} + 36'(m_q);
    trial   = {rem_q, sh_q[17]};
    dvs     = {1'b0, m_q, 1'b0};
    qbit    = trial >= dvs;

    mul_a = {c_q[17], c_q};
    mul_b = 18'(vx_q);
    if (state_q == ST_SCALE_MUL) begin
      mul_a = {1'b0, cur_abs};
      mul_b = {1'b0, lim_q};
    end else begin
      unique case (cnt_q[1:0])
        2'd0: begin mul_a = {c_q[17], c_q}; mul_b = 18'(vx_q); end
        2'd1: begin mul_a = {s_q[17], s_q}; mul_b = 18'(vy_q); end
        2'd2: begin mul_a = {c_q[17], c_q}; mul_b = 18'(vy_q); end
        default: begin mul_a = {s_q[17], s_q}; mul_b = 18'(vx_q); end
      endcase
    end
    acc_sum = (cnt_q[1:0] == 2'd3) ? acc_q - 38'(prod) : acc_q + 38'(prod);

    // Rotation rate choice.
    wz_sel = 18'(corr_q);
    dir_d  = dir_q;
    if (wzc_q != 16'sd0) begin
      wz_sel = 18'(wzc_q);
      dir_d  = wzc_q[15] ? DIR_NEG : DIR_POS;
    end else if (dir_q != DIR_NONE) begin
      if (ayaw > {1'b0, deadband_q}) begin
        wz_sel = (dir_q == DIR_POS) ? 18'sd256 : -18'sd256;
      end else begin
        dir_d = DIR_NONE;
      end
    end
    mix[0] = -20'(rx_q) + 20'(ry_q) + 20'(wz_sel);
    mix[1] =  20'(rx_q) + 20'(ry_q) + 20'(wz_sel);
    mix[2] =  20'(rx_q) - 20'(ry_q) + 20'(wz_sel);
    mix[3] = -20'(rx_q) - 20'(ry_q) + 20'(wz_sel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dir_q       <= DIR_NONE;
      cnt_q       <= '0;
      idx_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dir_q       <= (state_q == ST_MIX) ? dir_d : dir_q;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    yaw_q  <= yaw_d;
    vx_q   <= vx_d;
    vy_q   <= vy_d;
    wzc_q  <= wzc_d;
    corr_q <= corr_d;
    neg_q  <= neg_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    c_q    <= c_d;
    s_q    <= s_d;
    acc_q  <= acc_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    w_q    <= w_d;
    spin_q <= spin_d;
    m_q    <= m_d;
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    out_w_q    <= out_w_d;
    out_spin_q <= out_spin_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    done_d  = done_q;
    yaw_d = yaw_q; vx_d = vx_q; vy_d = vy_q; wzc_d = wzc_q; corr_d = corr_q;
    neg_d = neg_q; x_d = x_q; y_d = y_q; z_d = z_q; c_d = c_q; s_d = s_q;
    acc_d = acc_q; rx_d = rx_q; ry_d = ry_q; w_d = w_q; spin_d = spin_q;
    m_d = m_q; rem_d = rem_q; sh_d = sh_q;
    out_w_d    = out_w_q;
    out_spin_d = out_spin_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = (state_q != ST_IDLE) || done_q;

    // A finished result moves to the output register once that register is free.
    if (done_q && !(out_valid_q && out_stall_i)) begin
      out_w_d     = w_q;
      out_spin_d  = spin_q;
      out_valid_d = 1'b1;
      done_d      = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          yaw_d = yaw_angle_i; vx_d = cmd_vx_i; vy_d = cmd_vy_i;
          wzc_d = cmd_wz_i; corr_d = follow_correction_i;
          x_d = CORDIC_GAIN; y_d = '0; cnt_d = '0;
          if (z_init > Q28_HALF_PI) begin
            z_d = z_init - Q28_PI; neg_d = 1'b1;
          end else if (z_init < -Q28_HALF_PI) begin
            z_d = z_init + Q28_PI; neg_d = 1'b1;
          end else begin
            z_d = z_init; neg_d = 1'b0;
          end
          if (no_force_i) begin
            for (int i = 0; i < 4; i++) w_d[i] = '0;
            spin_d = 1'b0;
            done_d = 1'b1;
          end else begin
            state_d = ST_CORDIC;
          end
        end
      end
      ST_CORDIC: begin
        if (!z_q[31]) begin
          x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - atan_q28(cnt_q[3:0]);
        end else begin
          x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + atan_q28(cnt_q[3:0]);
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(CordicSteps - 1)) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        c_d   = neg_q ? -xr[17:0] : xr[17:0];
        s_d   = neg_q ? -yr[17:0] : yr[17:0];
        cnt_d = '0;
        state_d = ST_ROTATE;
      end
      ST_ROTATE: begin
        cnt_d = cnt_q + 5'd1;
        unique case (cnt_q[1:0])
          2'd0, 2'd2: acc_d = 38'(prod);
          2'd1: rx_d = 18'((acc_sum + 38'sd8192) >>> 14);
          default: begin
            ry_d    = 18'((acc_sum + 38'sd8192) >>> 14);
            state_d = ST_MIX;
          end
        endcase
      end
      ST_MIX: begin
        for (int i = 0; i < 4; i++) w_d[i] = mix[i][17:0];
        spin_d  = wzc_q >= spin_thr_q;
        state_d = ST_MAX;
      end
      ST_MAX: begin
        m_d   = (m01 > m23) ? m01 : m23;
        idx_d = '0;
        if (((m01 > m23) ? m01 : m23) > {1'b0, lim_q}) begin
          state_d = ST_SCALE_MUL;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCALE_MUL: begin
        rem_d   = {1'b0, num[35:18]};
        sh_d    = num[17:0];
        cnt_d   = '0;
        state_d = ST_SCALE_DIV;
      end
      ST_SCALE_DIV: begin
        rem_d = qbit ? 19'(trial - dvs) : trial[18:0];
        sh_d  = {sh_q[16:0], qbit};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(DivSteps - 1)) begin
          w_d[idx_q] = cur_neg ? -{sh_q[16:0], qbit} : {sh_q[16:0], qbit};
          idx_d      = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_SCALE_MUL;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o         = out_valid_q;
  assign speed_left_back_o   = out_w_q[0];
  assign speed_right_back_o  = out_w_q[1];
  assign speed_right_front_o = out_w_q[2];
  assign speed_left_front_o  = out_w_q[3];
  assign spinning_o          = out_spin_q;

  // The remembered direction never takes the unused code.
  a_dir_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_q != DIR_ODD) else $error("spin direction took the unused code");

  // A transaction that needs work leaves the idle state on the next cycle.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !no_force_i |=> state_q == ST_CORDIC)
    else $error("sequencer did not start");

  // A no-force transaction holds a finished result and leaves the direction alone.
  a_no_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && no_force_i |=> done_q && state_q == ST_IDLE && $stable(dir_q))
    else $error("no-force transaction mishandled");

  // A pending result always blocks new transactions.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> in_stall_o) else $error("accepted while a result was pending");

endmodule

// ----- test/tb_chassis_wheel_speed_mixer.sv -----
// Self-checking testbench for the chassis wheel speed mixer.
// Predicts wheel speeds and the spin flag per transaction and checks them in order.
// Depends on cwsm_pkg and chassis_wheel_speed_mixer.
module tb_chassis_wheel_speed_mixer;
  import cwsm_pkg::*;

  // One command transaction as it is presented to the block.
  typedef struct packed {
    logic signed [14:0] yaw;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] wz;
    logic signed [15:0] corr;
    logic               nf;
  } command_t;

  // One expected set of wheel speeds.
  typedef struct packed {
    logic signed [17:0] lb;
    logic signed [17:0] rb;
    logic signed [17:0] rf;
    logic signed [17:0] lf;
    logic               spin;
  } wheel_set_t;

  localparam int unsigned CycleLimit = 1500000;

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [16:0] cfg_data;
  logic in_valid, in_stall;
  command_t cur_cmd;
  logic out_valid, out_stall;
  logic signed [17:0] lb_o, rb_o, rf_o, lf_o;
  logic spin_o;

  // The predictor keeps its own copy of the configuration and the spin memory.
  logic [16:0] lim_q;
  logic [13:0] deadband_q;
  logic signed [15:0] thr_q;
  cwsm_dir_e dir_q;

  command_t pending_cmds[$];
  wheel_set_t expected_wheels[$];
  int unsigned mismatches, checked, cycles, gap_left, stall_left;
  bit feeding;

  chassis_wheel_speed_mixer i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .yaw_angle_i(cur_cmd.yaw), .cmd_vx_i(cur_cmd.vx), .cmd_vy_i(cur_cmd.vy),
    .cmd_wz_i(cur_cmd.wz), .follow_correction_i(cur_cmd.corr), .no_force_i(cur_cmd.nf),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .speed_left_back_o(lb_o), .speed_right_back_o(rb_o),
    .speed_right_front_o(rf_o), .speed_left_front_o(lf_o), .spinning_o(spin_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Arithmetic shift right on 64-bit signed values.
  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  // Sine and cosine of the yaw in Q.14, by folding into +-pi/2 and running CORDIC.
  function automatic void yaw_sin_cos(input logic signed [14:0] yaw,
                                      output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(yaw) * 65536;
    x = CORDIC_GAIN;
    y = 0;
    flip = 0;
    if (z > Q28_HALF_PI) begin
      z -= Q28_PI;
      flip = 1;
    end else if (z < -longint'(Q28_HALF_PI)) begin
      z += Q28_PI;
      flip = 1;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      dx = asr64(y, i);
      dy = asr64(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_q28(i[3:0]);
      end else begin
        x += dx;
        y -= dy;
        z += atan_q28(i[3:0]);
      end
    end
    x = asr64(x + 8192, 14);
    y = asr64(y + 8192, 14);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Works out the wheel speeds for one command and updates the spin memory.
  function automatic wheel_set_t mix_wheels(command_t cmd);
    wheel_set_t r;
    longint s, c, rx, ry, wz, m, a, q, lim, ayaw;
    longint w[4];
    r = '0;
    if (cmd.nf) return r;
    yaw_sin_cos(cmd.yaw, s, c);
    rx = asr64(c * cmd.vx + s * cmd.vy + 8192, 14);
    ry = asr64(c * cmd.vy - s * cmd.vx + 8192, 14);
    ayaw = cmd.yaw < 0 ? -longint'(cmd.yaw) : longint'(cmd.yaw);
    if (cmd.wz != 0) begin
      wz = cmd.wz;
      dir_q = cmd.wz > 0 ? DIR_POS : DIR_NEG;
    end else if (dir_q != DIR_NONE) begin
      if (ayaw > longint'(deadband_q)) begin
        wz = (dir_q == DIR_POS) ? 256 : -256;
      end else begin
        wz = cmd.corr;
        dir_q = DIR_NONE;
      end
    end else begin
      wz = cmd.corr;
    end
    w[0] = -rx + ry + wz;
    w[1] = rx + ry + wz;
    w[2] = rx - ry + wz;
    w[3] = -rx - ry + wz;
    m = 0;
    for (int i = 0; i < 4; i++) begin
      a = w[i] < 0 ? -w[i] : w[i];
      if (a > m) m = a;
    end
    lim = lim_q;
    if (m > lim) begin
      for (int i = 0; i < 4; i++) begin
        a = w[i] < 0 ? -w[i] : w[i];
        q = (2 * a * lim + m) / (2 * m);
        w[i] = w[i] < 0 ? -q : q;
      end
    end
    r.lb = w[0][17:0];
    r.rb = w[1][17:0];
    r.rf = w[2][17:0];
    r.lf = w[3][17:0];
    r.spin = cmd.wz >= thr_q;
    return r;
  endfunction

  function automatic logic [15:0] rand_q78();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 2048)) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic command_t rand_cmd();
    command_t t;
    t.yaw  = 15'($urandom);
    if ($urandom_range(0, 3) != 0) t.yaw = 15'(int'($urandom_range(0, 25736)) - 12868);
    t.vx   = rand_q78();
    t.vy   = rand_q78();
    t.wz   = ($urandom_range(0, 2) == 0) ? rand_q78() : 16'sd0;
    t.corr = rand_q78();
    t.nf   = ($urandom_range(0, 15) == 0);
    return t;
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Driver: takes the next command off the queue once the previous one has gone in.
  // The expectation is formed when the block accepts the transaction.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cur_cmd  <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_wheels.push_back(mix_wheels(cur_cmd));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (feeding && pending_cmds.size() != 0) begin
          cur_cmd  <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          gap_left <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk or negedge rst_n) begin
    wheel_set_t exp_w;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_wheels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result transaction at cycle %0d", cycles);
        end else begin
          exp_w = expected_wheels.pop_front();
          checked++;
          if (exp_w !== {lb_o, rb_o, rf_o, lf_o, spin_o}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch at cycle %0d: expected %0d %0d %0d %0d spin %0b, got %0d %0d %0d %0d spin %0b",
                       cycles, exp_w.lb, exp_w.rb, exp_w.rf, exp_w.lf, exp_w.spin,
                       lb_o, rb_o, rf_o, lf_o, spin_o);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left <= gap_len();
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Run exceeded its cycle limit with %0d results outstanding", expected_wheels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Writes one register while the block is idle and mirrors it in the predictor.
  task automatic write_reg(cwsm_reg_e idx, logic [16:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_LIMIT: lim_q = val;
      REG_DEADBAND:  deadband_q = val[13:0];
      REG_SPIN_THR:  thr_q = val[15:0];
      default: ;
    endcase
  endtask

  // Lets the queued commands run through, then waits until the block is quiet.
  // The queues are looked at on the falling edge, once the driver has settled.
  task automatic run_phase();
    feeding = 1;
    while (pending_cmds.size() != 0 || in_valid || expected_wheels.size() != 0) @(negedge clk);
    feeding = 0;
    repeat (120) @(posedge clk);
  endtask

  task automatic push_cmd(int yaw, int vx, int vy, int wz, int corr, bit nf);
    command_t t;
    t.yaw = 15'(yaw);
    t.vx = 16'(vx);
    t.vy = 16'(vy);
    t.wz = 16'(wz);
    t.corr = 16'(corr);
    t.nf = nf;
    pending_cmds.push_back(t);
  endtask

  // Mostly short spin-and-return episodes with random content, mixed with loose commands.
  task automatic push_random(int unsigned n);
    command_t t;
    repeat (n) begin
      t = rand_cmd();
      if ($urandom_range(0, 2) == 0) begin
        t.wz = 16'(int'($urandom_range(1, 2000)) * ($urandom_range(0, 1) ? 1 : -1));
        pending_cmds.push_back(t);
        repeat ($urandom_range(1, 4)) begin
          t = rand_cmd();
          t.wz = 0;
          if ($urandom_range(0, 1)) t.yaw = 15'(int'($urandom_range(0, 600)) - 300);
          pending_cmds.push_back(t);
        end
      end else begin
        pending_cmds.push_back(t);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_MAX_LIMIT;
    cfg_data = '0;
    feeding = 0;
    mismatches = 0;
    checked = 0;
    cycles = 0;
    lim_q = 17'd131071;
    deadband_q = 14'd205;
    thr_q = 16'sd26;
    dir_q = DIR_NONE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under reset defaults: field extremes, yaw fold points, the
    // return spin in both directions and its release inside the deadband, no force.
    push_cmd(0, 32767, 32767, 32767, 0, 0);
    push_cmd(-16384, -32768, -32768, -32768, -32768, 0);
    push_cmd(16383, 32767, -32768, 0, 32767, 0);
    push_cmd(12868, 1000, 0, 0, 0, 0);
    push_cmd(-12868, 0, 1000, 0, 0, 0);
    push_cmd(6434, 256, 256, 25, 0, 0);
    push_cmd(1000, 0, 0, 26, 0, 0);
    push_cmd(1000, 100, 0, 0, 77, 0);
    push_cmd(205, 100, 0, 0, 77, 0);
    push_cmd(0, 0, 0, 0, 55, 0);
    push_cmd(-3000, 0, 0, -5, 0, 0);
    push_cmd(-3000, 0, 0, 0, 9, 0);
    push_cmd(5000, -1, -1, 0, 9, 1);
    push_cmd(-206, 0, 0, 0, 9, 0);
    push_cmd(-12, 0, 0, 0, -9, 0);
    push_cmd(-1, 32767, 32767, 32767, 32767, 1);
    run_phase();

    write_reg(REG_MAX_LIMIT, 17'd0);
    write_reg(REG_DEADBAND, 17'd0);
    write_reg(REG_SPIN_THR, 17'h08000);
    push_cmd(0, 32767, -32768, 32767, 0, 0);
    push_cmd(3, 5, 5, 0, 1, 0);
    push_random(100);
    run_phase();

    write_reg(REG_MAX_LIMIT, 17'd300);
    write_reg(REG_DEADBAND, 17'd12868);
    write_reg(REG_SPIN_THR, 17'h07fff);
    push_random(270);
    run_phase();

    write_reg(REG_MAX_LIMIT, 17'($urandom_range(1000, 60000)));
    write_reg(REG_DEADBAND, 17'($urandom_range(0, 12868)));
    write_reg(REG_SPIN_THR, 17'($urandom));
    push_random(270);
    run_phase();

    write_reg(REG_MAX_LIMIT, 17'd131071);
    write_reg(REG_DEADBAND, 17'd205);
    write_reg(REG_SPIN_THR, 17'd0);
    push_random(270);
    run_phase();

    $display("Checked %0d result transactions across five register settings,", checked);
    $display("including limit, deadband and threshold extremes and spin-return episodes.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
